>>> hdl/ccu_pkg.sv
// ----------------------------------------------------------------------------
// Combinatorial count unit package
// Shared widths, operation codes and status codes for the count unit and
// its port checker.
// ----------------------------------------------------------------------------
package ccu_pkg;

    // Field widths of the item channels.
    localparam int OP_W     = 3;
    localparam int CNT_W    = 6;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    // Largest count that is accepted and width of the exact result.
    localparam int MAX_COUNT    = 63;
    localparam int RESULT_WIDTH = 64;

    // Step factors reach n + k - 1, one bit wider than a count.
    localparam int FAC_W = CNT_W + 1;

    // Product of the accumulator and one factor, padded to whole bytes for
    // the divider, which retires eight quotient bits per cycle.
    localparam int PROD_W      = RESULT_WIDTH + FAC_W;
    localparam int DIV_W       = ((PROD_W + 7) / 8) * 8;
    localparam int DIV_CYCLES  = DIV_W / 8;
    localparam int DCNT_W      = $clog2(DIV_CYCLES);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_POWER = 3'd0;
    localparam logic [OP_W-1:0] OP_PERM  = 3'd1;
    localparam logic [OP_W-1:0] OP_MULTI = 3'd2;
    localparam logic [OP_W-1:0] OP_COMB  = 3'd3;
    localparam logic [OP_W-1:0] OP_FACT  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

>>> hdl/combinatorial_count_unit.sv
// ----------------------------------------------------------------------------
// Combinatorial count unit
// Computes n^k, k-permutations, combinations with repetition, combinations
// or n! exactly, with invalid-input and overflow flags.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries op, count_n and count_k.
// The output channel (out_valid / out_stall) returns one item per input
// item: value and status. Status is ok, invalid input or overflow; value
// is zero unless status is ok.
// The block works on one item at a time and holds in_stall high until the
// result has been loaded into the output register.
// Each item runs a loop of steps on the shared 64 x 7 multiplier; the two
// binomial forms also pass every product through the radix-256 exact
// divider. The number of steps is k for power and permutations, n for
// factorial and min(k, m - k) for the binomials.
// An overflow ends the loop early. Invalid items skip the loop and go to S_FIN.
// When the receiver stalls, the result stays in the output register and
// the next finished result waits in the sequencer until it is taken.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module combinatorial_count_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ccu_pkg::OP_W-1:0]       op,
    input  logic [ccu_pkg::CNT_W-1:0]      count_n,
    input  logic [ccu_pkg::CNT_W-1:0]      count_k,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ccu_pkg::VALUE_W-1:0]    value,
    output logic [ccu_pkg::STATUS_W-1:0]   status
);
    import ccu_pkg::*;

    // Sequencer state codes.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [CNT_W+1:0] MAX_CNT = (CNT_W+2)'(MAX_COUNT);

    logic [1:0]              state_reg,     state_next;
    logic                    power_reg,     power_next;
    logic                    binom_reg,     binom_next;
    logic [FAC_W-1:0]        m_reg,         m_next;
    logic [CNT_W-1:0]        cnt_reg,       cnt_next;
    logic [CNT_W-1:0]        i_reg,         i_next;
    logic [RESULT_WIDTH-1:0] acc_reg,       acc_next;
    logic [DIV_W-1:0]        dq_reg,        dq_next;
    logic [FAC_W-1:0]        rem_reg,       rem_next;
    logic [DCNT_W-1:0]       dcnt_reg,      dcnt_next;
    logic [STATUS_W-1:0]     st_reg,        st_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]      value_reg,     value_next;
    logic [STATUS_W-1:0]     status_reg,    status_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    bad_in;
    logic [FAC_W-1:0]        m_in;
    logic [FAC_W-1:0]        other_in;
    logic [FAC_W-1:0]        j_in;
    logic [CNT_W-1:0]        cnt_in;
    logic [FAC_W-1:0]        factor;
    logic [FAC_W-1:0]        den;
    logic [PROD_W-1:0]       prod;
    logic [FAC_W-1:0]        rem_v;
    logic [7:0]              top_bits;
    logic [7:0]              qbits;
    logic [7:0]              trial;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Operand check and loop setup for a new item.
    always_comb
    begin
        bad_in = 1'b0;
        if (op > OP_FACT)
            bad_in = 1'b1;
        if ({2'b00, count_n} > MAX_CNT)
            bad_in = 1'b1;
        if (op == OP_FACT)
        begin
            if (count_n == '0)
                bad_in = 1'b1;
        end
        else
        begin
            if ({2'b00, count_k} > MAX_CNT || count_k == '0 || count_n < count_k)
                bad_in = 1'b1;
        end

        if (op == OP_MULTI)
            m_in = {1'b0, count_n} + {1'b0, count_k} - FAC_W'(1);
        else
            m_in = {1'b0, count_n};

        // The binomials run over the smaller of k and m - k.
        other_in = m_in - {1'b0, count_k};
        j_in     = ({1'b0, count_k} < other_in) ? {1'b0, count_k} : other_in;

        if (op == OP_FACT)
            cnt_in = count_n;
        else if (op == OP_MULTI || op == OP_COMB)
            cnt_in = j_in[CNT_W-1:0];
        else
            cnt_in = count_k;
    end

    // Shared multiplier: accumulator times the current step factor.
    assign factor = power_reg ? m_reg : (m_reg - {1'b0, i_reg});
    assign den    = {1'b0, i_reg} + FAC_W'(1);
    assign prod   = PROD_W'(acc_reg) * PROD_W'(factor);

    // Exact divider: eight restoring steps on the top byte of the dividend.
    always_comb
    begin
        rem_v    = rem_reg;
        top_bits = dq_reg[DIV_W-1 -: 8];
        qbits    = '0;
        trial    = '0;
        for (int b = 7; b >= 0; b--)
        begin
            trial = {rem_v, top_bits[b]};
            if (trial >= {1'b0, den})
            begin
                rem_v    = FAC_W'(trial - {1'b0, den});
                qbits[b] = 1'b1;
            end
            else
            begin
                rem_v = trial[FAC_W-1:0];
            end
        end
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        power_next     = power_reg;
        binom_next     = binom_reg;
        m_next         = m_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        acc_next       = acc_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    power_next = (op == OP_POWER);
                    binom_next = (op == OP_MULTI) || (op == OP_COMB);
                    m_next     = m_in;
                    cnt_next   = cnt_in;
                    i_next     = '0;
                    acc_next   = RESULT_WIDTH'(1);
                    if (bad_in)
                    begin
                        st_next    = ST_INVALID;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                if (i_reg == cnt_reg)
                begin
                    state_next = S_FIN;
                end
                else if (binom_reg)
                begin
                    dq_next    = DIV_W'(prod);
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
                else if (prod[PROD_W-1:RESULT_WIDTH] != '0)
                begin
                    st_next    = ST_OVERFLOW;
                    state_next = S_FIN;
                end
                else
                begin
                    acc_next = prod[RESULT_WIDTH-1:0];
                    i_next   = i_reg + CNT_W'(1);
                end
            end

            S_DIV:
            begin
                dq_next   = {dq_reg[DIV_W-9:0], qbits};
                rem_next  = rem_v;
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_CYCLES - 1))
                begin
                    // Quotient is the next binomial coefficient.
                    if (dq_next[DIV_W-1:RESULT_WIDTH] != '0)
                    begin
                        st_next    = ST_OVERFLOW;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        acc_next   = dq_next[RESULT_WIDTH-1:0];
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_MUL;
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    value_next     = (st_reg == ST_OK) ? VALUE_W'(acc_reg) : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        power_reg  <= power_next;
        binom_reg  <= binom_next;
        m_reg      <= m_next;
        cnt_reg    <= cnt_next;
        i_reg      <= i_next;
        acc_reg    <= acc_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        st_reg     <= st_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

>>> hdl/ccu_checker.sv
// ----------------------------------------------------------------------------
// Combinatorial count unit port checker
// Watches the ports of the count unit and flags illegal behavior over time.
// ----------------------------------------------------------------------------
module ccu_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [ccu_pkg::OP_W-1:0]       op,
    input  logic [ccu_pkg::CNT_W-1:0]      count_n,
    input  logic [ccu_pkg::CNT_W-1:0]      count_k,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [ccu_pkg::VALUE_W-1:0]    value,
    input  logic [ccu_pkg::STATUS_W-1:0]   status
);
    import ccu_pkg::*;

    // A failed item always reports a zero value.
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value == '0)
        else $error("nonzero value with a failing status");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_INVALID || status == ST_OVERFLOW))
        else $error("undefined status code");

    // After taking an item the block is busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was taken");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

endmodule

bind combinatorial_count_unit ccu_checker u_ccu_checker (.*);
